[rtl/assert_macros.svh]
// Assertion helpers for the RTL files; line_rasterizer_core.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset.
`define AST_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every rising edge, reset included.
`define AST_CHECK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[rtl/lrast_pkg.sv]
`default_nettype none

package lrast_pkg;

   localparam int FIELD_BITS     = 16;
   localparam int COLOR_BITS     = 24;
   localparam int COORD_BITS_DEF = 16;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [FIELD_BITS-1:0] SCREEN_SIZE_RESET = 16'd360;

   typedef struct packed {
      logic                  req_type;
      logic [FIELD_BITS-1:0] start_x;
      logic [FIELD_BITS-1:0] start_y;
      logic [FIELD_BITS-1:0] end_x;
      logic [FIELD_BITS-1:0] end_y;
      logic [FIELD_BITS-1:0] draw_color;
   } lrast_req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] pixel_x;
      logic [FIELD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  on_screen;
      logic                  last_pixel;
   } lrast_rsp_type;

   // Widens RGB565 to RGB888 by repeating the top bits of each channel.
   function automatic logic [COLOR_BITS-1:0] widen_color(input logic [15:0] c);
      logic [4:0] r5;
      logic [5:0] g6;
      logic [4:0] b5;
      r5 = c[15:11];
      g6 = c[10:5];
      b5 = c[4:0];
      return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
   endfunction

endpackage

`default_nettype wire

[rtl/lrast_step.sv]
`default_nettype none

module lrast_step #(
   parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0]        pos_x,
   input  logic [COORD_BITS-1:0]        pos_y,
   input  logic [COORD_BITS-1:0]        span_x,
   input  logic [COORD_BITS-1:0]        span_y,
   input  logic signed [COORD_BITS+1:0] err,
   input  logic                         step_left,
   input  logic                         step_up,
   output logic [COORD_BITS-1:0]        next_x,
   output logic [COORD_BITS-1:0]        next_y,
   output logic signed [COORD_BITS+1:0] next_err
);
   import lrast_pkg::*;

   localparam int ERR_BITS  = COORD_BITS + 2;
   localparam int WIDE_BITS = ERR_BITS + 1;

   logic signed [WIDE_BITS-1:0] err_twice;
   logic signed [WIDE_BITS-1:0] dx_wide;
   logic signed [WIDE_BITS-1:0] dy_wide;
   logic signed [WIDE_BITS-1:0] err_sum;
   logic                        move_x;
   logic                        move_y;

   always_comb begin
      err_twice = signed'({err, 1'b0});
      dx_wide   = signed'(WIDE_BITS'(span_x));
      dy_wide   = -signed'(WIDE_BITS'(span_y));
      move_x    = err_twice >= dy_wide;
      move_y    = err_twice <= dx_wide;
      err_sum   = signed'({err[ERR_BITS-1], err})
                  + (move_x ? dy_wide : '0)
                  + (move_y ? dx_wide : '0);
      next_err  = err_sum[ERR_BITS-1:0];

      next_x = pos_x;
      if (move_x) begin
         next_x = step_left ? pos_x - COORD_BITS'(1) : pos_x + COORD_BITS'(1);
      end
      next_y = pos_y;
      if (move_y) begin
         next_y = step_up ? pos_y - COORD_BITS'(1) : pos_y + COORD_BITS'(1);
      end
   end

endmodule

`default_nettype wire

[rtl/line_rasterizer_core.sv]
`default_nettype none
`include "assert_macros.svh"

// Bresenham line generator, all octants. A start item loads both endpoints and an
// RGB565 color and gives no result; each tick item then returns one pixel with its
// RGB888 color, an on-screen flag against the screen size registers and a flag on
// the end point. A tick while no line is active gives nothing, and a start during a
// line replaces it. The line state is stepped by one error-term update between
// the state registers and the result register, and a new item is taken each cycle
// unless a result is held in the result register waiting for rsp_ready. Screen size
// registers reset to 360 and should be written while idle.

module line_rasterizer_core #(
   parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  lrast_pkg::lrast_req_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output lrast_pkg::lrast_rsp_type        rsp_payload,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [lrast_pkg::FIELD_BITS-1:0] csr_wdata
);
   import lrast_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 2;

   logic [FIELD_BITS-1:0]        width_ff, width_in;
   logic [FIELD_BITS-1:0]        height_ff, height_in;
   logic [COORD_BITS-1:0]        pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]        pos_y_ff, pos_y_in;
   logic [COORD_BITS-1:0]        target_x_ff, target_x_in;
   logic [COORD_BITS-1:0]        target_y_ff, target_y_in;
   logic [COORD_BITS-1:0]        span_x_ff, span_x_in;
   logic [COORD_BITS-1:0]        span_y_ff, span_y_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic                         step_left_ff, step_left_in;
   logic                         step_up_ff, step_up_in;
   logic [COLOR_BITS-1:0]        rgb_ff, rgb_in;
   logic                         busy_ff, busy_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lrast_rsp_type                rsp_ff, rsp_in;

   logic [COORD_BITS-1:0]        x0, y0, x1, y1;
   logic [COORD_BITS-1:0]        next_x, next_y;
   logic signed [ERR_BITS-1:0]   next_err;
   logic                         accept;
   logic                         emit;
   logic                         at_end;

   lrast_step #(
      .COORD_BITS(COORD_BITS)
   ) u_step (
      .pos_x     (pos_x_ff),
      .pos_y     (pos_y_ff),
      .span_x    (span_x_ff),
      .span_y    (span_y_ff),
      .err       (err_ff),
      .step_left (step_left_ff),
      .step_up   (step_up_ff),
      .next_x    (next_x),
      .next_y    (next_y),
      .next_err  (next_err)
   );

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign at_end      = (pos_x_ff == target_x_ff) && (pos_y_ff == target_y_ff);
   assign emit        = accept && (req_payload.req_type == REQ_TICK) && busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      x0 = req_payload.start_x[COORD_BITS-1:0];
      y0 = req_payload.start_y[COORD_BITS-1:0];
      x1 = req_payload.end_x[COORD_BITS-1:0];
      y1 = req_payload.end_y[COORD_BITS-1:0];

      width_in     = width_ff;
      height_in    = height_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      err_in       = err_ff;
      step_left_in = step_left_ff;
      step_up_in   = step_up_ff;
      rgb_in       = rgb_ff;
      busy_in      = busy_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wdata;
            CSR_SCREEN_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept && (req_payload.req_type == REQ_START)) begin
         pos_x_in     = x0;
         pos_y_in     = y0;
         target_x_in  = x1;
         target_y_in  = y1;
         step_left_in = !(x0 < x1);
         step_up_in   = !(y0 < y1);
         span_x_in    = (x0 < x1) ? x1 - x0 : x0 - x1;
         span_y_in    = (y0 < y1) ? y1 - y0 : y0 - y1;
         err_in       = signed'(ERR_BITS'(span_x_in)) - signed'(ERR_BITS'(span_y_in));
         rgb_in       = widen_color(req_payload.draw_color);
         busy_in      = 1'b1;
      end

      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_in.pixel_x     = FIELD_BITS'(pos_x_ff);
         rsp_in.pixel_y     = FIELD_BITS'(pos_y_ff);
         rsp_in.pixel_color = rgb_ff;
         rsp_in.on_screen   = (FIELD_BITS'(pos_x_ff) < width_ff)
                              && (FIELD_BITS'(pos_y_ff) < height_ff);
         rsp_in.last_pixel  = at_end;
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            pos_x_in = next_x;
            pos_y_in = next_y;
            err_in   = next_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SCREEN_SIZE_RESET;
         height_ff    <= SCREEN_SIZE_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         target_x_ff  <= '0;
         target_y_ff  <= '0;
         span_x_ff    <= '0;
         span_y_ff    <= '0;
         err_ff       <= '0;
         step_left_ff <= 1'b0;
         step_up_ff   <= 1'b0;
         rgb_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         target_x_ff  <= target_x_in;
         target_y_ff  <= target_y_in;
         span_x_ff    <= span_x_in;
         span_y_ff    <= span_y_in;
         err_ff       <= err_in;
         step_left_ff <= step_left_in;
         step_up_ff   <= step_up_in;
         rgb_ff       <= rgb_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   `AST_CHECK_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid && !busy_ff)
   `AST_CHECK(a_end_stops_line, clock, reset, emit && at_end |=> !busy_ff)
   `AST_CHECK(a_start_arms_line, clock, reset,
      accept && (req_payload.req_type == REQ_START) |=> busy_ff)
   `AST_CHECK(a_no_result_without_pixel, clock, reset, accept && !emit |=> !rsp_valid)

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import lrast_pkg::*;

   class line_tracker;
      logic [FIELD_BITS-1:0] screen_w;
      logic [FIELD_BITS-1:0] screen_h;
      logic [15:0]           pos_x;
      logic [15:0]           pos_y;
      logic [15:0]           target_x;
      logic [15:0]           target_y;
      logic [15:0]           span_x;
      logic [15:0]           span_y;
      logic signed [17:0]    err_term;
      logic                  step_left;
      logic                  step_up;
      logic                  line_active;
      logic [23:0]           line_rgb;
      lrast_rsp_type         expected_pixels[$];
      int                    failures;

      function new();
         screen_w    = SCREEN_SIZE_RESET;
         screen_h    = SCREEN_SIZE_RESET;
         pos_x       = '0;
         pos_y       = '0;
         target_x    = '0;
         target_y    = '0;
         span_x      = '0;
         span_y      = '0;
         err_term    = '0;
         step_left   = 1'b0;
         step_up     = 1'b0;
         line_active = 1'b0;
         line_rgb    = '0;
         failures    = 0;
      endfunction

      function void accept_item(lrast_req_type item);
         lrast_rsp_type pix;
         logic [15:0]   c;
         int            e2;
         int            next_err;
         if (item.req_type == REQ_START) begin
            pos_x     = item.start_x;
            pos_y     = item.start_y;
            target_x  = item.end_x;
            target_y  = item.end_y;
            step_left = !(item.start_x < item.end_x);
            step_up   = !(item.start_y < item.end_y);
            span_x    = step_left ? item.start_x - item.end_x : item.end_x - item.start_x;
            span_y    = step_up ? item.start_y - item.end_y : item.end_y - item.start_y;
            err_term  = 18'(int'(span_x) - int'(span_y));
            c         = item.draw_color;
            line_rgb  = {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
            line_active = 1'b1;
         end else if (line_active) begin
            pix.pixel_x     = pos_x;
            pix.pixel_y     = pos_y;
            pix.pixel_color = line_rgb;
            pix.on_screen   = (pos_x < screen_w) && (pos_y < screen_h);
            pix.last_pixel  = (pos_x == target_x) && (pos_y == target_y);
            expected_pixels.push_back(pix);
            if (pix.last_pixel) begin
               line_active = 1'b0;
            end else begin
               e2       = 2 * int'(err_term);
               next_err = int'(err_term);
               if (e2 >= -int'(span_y)) begin
                  next_err -= int'(span_y);
                  pos_x = step_left ? pos_x - 16'd1 : pos_x + 16'd1;
               end
               if (e2 <= int'(span_x)) begin
                  next_err += int'(span_x);
                  pos_y = step_up ? pos_y - 16'd1 : pos_y + 16'd1;
               end
               err_term = 18'(next_err);
            end
         end
      endfunction

      function void check_pixel(lrast_rsp_type got);
         lrast_rsp_type want;
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y);
            failures++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x) begin
            $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
            failures++;
         end
         if (got.pixel_y !== want.pixel_y) begin
            $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
            failures++;
         end
         if (got.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %06h, got %06h", want.pixel_color, got.pixel_color);
            failures++;
         end
         if (got.on_screen !== want.on_screen) begin
            $error("on_screen: expected %0d, got %0d", want.on_screen, got.on_screen);
            failures++;
         end
         if (got.last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   lrast_req_type         req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   lrast_rsp_type         rsp_payload;
   logic                  csr_we;
   logic                  csr_index;
   logic [FIELD_BITS-1:0] csr_wdata;

   line_tracker tracker = new();
   bit          gaps_on = 1'b1;
   int          counted_items = 0;

   line_rasterizer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #4000000;
      $display("tb_top: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_pixel(rsp_payload);
      end
   end

   initial begin
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         if (gaps_on && $urandom_range(0, 1) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   function automatic int clamp16(int v);
      return v < 0 ? 0 : (v > 65535 ? 65535 : v);
   endfunction

   function automatic int pick_coord(int screen);
      int c;
      case ($urandom_range(0, 3))
         0: c = screen + int'($urandom_range(0, 16)) - 8;
         1: c = 65535 - int'($urandom_range(0, 15));
         2: c = int'($urandom_range(0, 20));
         default: c = int'($urandom_range(0, 65535));
      endcase
      return clamp16(c);
   endfunction

   function automatic lrast_req_type make_start(int x0, int y0, int x1, int y1, int color);
      lrast_req_type item;
      item.req_type   = REQ_START;
      item.start_x    = 16'(x0);
      item.start_y    = 16'(y0);
      item.end_x      = 16'(x1);
      item.end_y      = 16'(y1);
      item.draw_color = 16'(color);
      return item;
   endfunction

   function automatic lrast_req_type make_tick();
      lrast_req_type item;
      item.req_type   = REQ_TICK;
      item.start_x    = 16'($urandom);
      item.start_y    = 16'($urandom);
      item.end_x      = 16'($urandom);
      item.end_y      = 16'($urandom);
      item.draw_color = 16'($urandom);
      return item;
   endfunction

   task automatic send_item(input lrast_req_type item);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (item.req_type == REQ_START || tracker.line_active) begin
         counted_items++;
      end
      tracker.accept_item(item);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(make_tick());
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_screen(input int w, input int h);
      send_item(make_start(0, 0, 0, 0, 0));
      send_item(make_tick());
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= 16'(w);
      @(posedge clock);
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= 16'(h);
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.screen_w = 16'(w);
      tracker.screen_h = 16'(h);
   endtask

   initial begin
      int            widths[7];
      int            heights[7];
      int            x0;
      int            y0;
      int            x1;
      int            y1;
      int            n;
      int            goal;
      lrast_req_type item;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_SCREEN_WIDTH;
      csr_wdata   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_ticks(1);
      send_item(make_start(0, 0, 0, 0, 16'hFFFF));
      send_ticks(1);
      send_item(make_start(0, 0, 5, 2, 16'hF800));
      send_ticks(2);
      send_item(make_start(65535, 65535, 65530, 65533, 16'h07E0));
      send_ticks(7);
      send_item(make_start(359, 355, 362, 361, 16'h001F));
      send_ticks(7);
      send_item(make_start(0, 65535, 65535, 0, 16'h0000));
      send_ticks(2);

      widths  = '{360, 0, 1, 65535, 65535, $urandom_range(1, 400), $urandom_range(1, 400)};
      heights = '{360, 0, 65535, 1, 65535, $urandom_range(1, 400), $urandom_range(1, 400)};
      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) begin
            set_screen(widths[phase], heights[phase]);
         end
         if (phase == 6) begin
            gaps_on = 1'b0;
         end
         goal = counted_items + 240;
         while (counted_items < goal) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: begin
                  x0 = pick_coord(tracker.screen_w);
                  y0 = pick_coord(tracker.screen_h);
                  x1 = clamp16(x0 + int'($urandom_range(0, 24)) - 12);
                  y1 = clamp16(y0 + int'($urandom_range(0, 24)) - 12);
                  n  = (x1 > x0 ? x1 - x0 : x0 - x1);
                  if ((y1 > y0 ? y1 - y0 : y0 - y1) > n) begin
                     n = (y1 > y0 ? y1 - y0 : y0 - y1);
                  end
                  n = n + 1;
                  send_item(make_start(x0, y0, x1, y1, $urandom_range(0, 65535)));
                  case ($urandom_range(0, 4))
                     0: n = $urandom_range(0, n - 1);
                     1: n = n + $urandom_range(1, 2);
                     default: ;
                  endcase
                  send_ticks(n);
               end
               7: begin
                  item = make_tick();
                  item.req_type = REQ_START;
                  send_item(item);
                  send_ticks($urandom_range(0, 4));
               end
               8: send_ticks(1);
               default: begin
                  item = make_tick();
                  item.req_type = ($urandom_range(0, 1) == 1) ? REQ_TICK : REQ_START;
                  send_item(item);
               end
            endcase
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
